// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the pfsd_checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/pfsd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfsd_pkg
// types and constants shared by the pid filter list update block
// ---------------------------------------------------------------------------
package pfsd_pkg;

	localparam int PID_W = 16;
	localparam logic [PID_W-1:0] EMPTY_PID = 16'hFFFF;

	localparam logic CMD_REMOVE = 1'b0;
	localparam logic CMD_ADD    = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;        // store one incoming entry
		logic look;        // fetch candidate and compare against the other list
		logic sel_new;     // candidate comes from the new list (add pass)
		logic take_hit;    // capture the candidate as the pending result
		logic push;        // move the pending result to the output register
		logic push_final;  // pushed result closes this update
		logic copy;        // new list replaces the stored list
	} pfsd_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic hit;         // candidate is non-empty and absent from the other list
		logic pend_valid;  // a result waits in the pending register
		logic out_free;    // output register can take a result this cycle
	} pfsd_stat_t;

endpackage

// ===== hw/rtl/pid_filter_set_diff_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_filter_set_diff_core
// pid filter list update: remove and add commands between new and stored list
// ---------------------------------------------------------------------------
// Entries of a new list are taken one per cycle, 65535 marking an empty slot;
// entries past LIST_SIZE are dropped and an early last leaves the remaining
// slots empty. The transaction that carries last starts the comparison and
// item_ready stays low until it is done: a remove pass over the stored list,
// then an add pass over the new list, each slot taking a look step (fetch and
// compare against all slots of the other list in one comparator bank) and
// then a decide step, followed by a flush step and a copy step. Results come
// out through a one-deep output register; final_res marks the last command
// of an update, and an update with no difference produces no result at all.
module pid_filter_set_diff_core #(
	parameter int LIST_SIZE = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic [pfsd_pkg::PID_W-1:0] pid,
	input  logic                       last,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       command,
	output logic [pfsd_pkg::PID_W-1:0] pid_res,
	output logic                       final_res
);
	import pfsd_pkg::*;

	localparam int IDX_W  = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
	localparam int FILL_W = $clog2(LIST_SIZE + 1);

	pfsd_cmd_t        cmd;
	pfsd_stat_t       stat;
	logic [IDX_W-1:0] idx;

	// controller
	pfsd_ctrl #(
		.LIST_SIZE(LIST_SIZE),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.last      (last),
		.item_ready(item_ready),
		.stat      (stat),
		.cmd       (cmd),
		.idx       (idx)
	);

	// datapath
	pfsd_datapath #(
		.LIST_SIZE(LIST_SIZE),
		.IDX_W    (IDX_W),
		.FILL_W   (FILL_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.pid      (pid),
		.cmd      (cmd),
		.idx      (idx),
		.stat     (stat),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.command  (command),
		.pid_res  (pid_res),
		.final_res(final_res)
	);

endmodule

// ===== hw/rtl/pfsd_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfsd_ctrl
// controller: loads entries, walks both compare passes, flushes and copies
// ---------------------------------------------------------------------------
module pfsd_ctrl #(
	parameter int LIST_SIZE = 32,
	parameter int IDX_W     = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                last,
	output logic                item_ready,
	input  pfsd_pkg::pfsd_stat_t stat,
	output pfsd_pkg::pfsd_cmd_t  cmd,
	output logic [IDX_W-1:0]    idx
);
	import pfsd_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOK   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_FLUSH  = 3'd3;
	localparam logic [2:0] ST_COPY   = 3'd4;

	logic [2:0]       state_q, state_d;
	logic             phase_q, phase_d;   // 0 remove pass, 1 add pass
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             idx_end;
	logic             advance;

	assign idx_end    = (idx_q == IDX_W'(LIST_SIZE - 1));
	assign item_ready = (state_q == ST_IDLE);
	assign idx        = idx_q;

	// a hit may proceed when the pending slot is empty or can drain to the output
	assign advance = !stat.hit || !stat.pend_valid || stat.out_free;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.sel_new = phase_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					if (last) begin
						state_d = ST_LOOK;
						phase_d = CMD_REMOVE;
						idx_d   = '0;
					end
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (advance) begin
					cmd.take_hit = stat.hit;
					cmd.push     = stat.hit && stat.pend_valid;
					if (idx_end) begin
						if (phase_q == CMD_REMOVE) begin
							phase_d = CMD_ADD;
							idx_d   = '0;
							state_d = ST_LOOK;
						end else begin
							state_d = ST_FLUSH;
						end
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_LOOK;
					end
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = ST_COPY;
				end else if (stat.out_free) begin
					cmd.push       = 1'b1;
					cmd.push_final = 1'b1;
					state_d        = ST_COPY;
				end
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= CMD_REMOVE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ===== hw/rtl/pfsd_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfsd_datapath
// list storage, compare bank, pending result and output register
// ---------------------------------------------------------------------------
module pfsd_datapath #(
	parameter int LIST_SIZE = 32,
	parameter int IDX_W     = 5,
	parameter int FILL_W    = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pfsd_pkg::PID_W-1:0]   pid,
	input  pfsd_pkg::pfsd_cmd_t          cmd,
	input  logic [IDX_W-1:0]             idx,
	output pfsd_pkg::pfsd_stat_t         stat,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         command,
	output logic [pfsd_pkg::PID_W-1:0]   pid_res,
	output logic                         final_res
);
	import pfsd_pkg::*;

	logic [PID_W-1:0]     act_q [LIST_SIZE];
	logic [PID_W-1:0]     inc_q [LIST_SIZE];
	logic [FILL_W-1:0]    fill_q;

	logic [PID_W-1:0]     cand;
	logic                 cand_ok;
	logic [LIST_SIZE-1:0] match_c;

	logic [PID_W-1:0]     cand_s1;
	logic                 cand_ok_s1;
	logic                 sel_new_s1;
	logic [LIST_SIZE-1:0] match_s1;

	logic                 pend_valid_q;
	logic                 pend_cmd_q;
	logic [PID_W-1:0]     pend_pid_q;

	logic                 out_valid_q;
	logic                 out_cmd_q;
	logic [PID_W-1:0]     out_pid_q;
	logic                 out_final_q;

	// candidate fetch: slots past the fill count of the new list read as empty
	always_comb begin
		if (cmd.sel_new) begin
			cand    = inc_q[idx];
			cand_ok = (FILL_W'(idx) < fill_q) && (inc_q[idx] != EMPTY_PID);
		end else begin
			cand    = act_q[idx];
			cand_ok = (act_q[idx] != EMPTY_PID);
		end
	end

	// compare bank, one comparator per slot of the other list
	always_comb begin
		for (int k = 0; k < LIST_SIZE; k++) begin
			if (cmd.sel_new) begin
				match_c[k] = (act_q[k] == cand);
			end else begin
				match_c[k] = (FILL_W'(k) < fill_q) && (inc_q[k] == cand);
			end
		end
	end

	// compare stage register
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			cand_s1    <= cand;
			cand_ok_s1 <= cand_ok;
			sel_new_s1 <= cmd.sel_new;
			match_s1   <= match_c;
		end
	end

	assign stat.hit        = cand_ok_s1 && !(|match_s1);
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = !out_valid_q || res_ready;

	// incoming list, written only at the fill position
	always_ff @(posedge clk) begin
		if (cmd.load && (fill_q < FILL_W'(LIST_SIZE))) begin
			inc_q[fill_q[IDX_W-1:0]] <= pid;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.copy) begin
			fill_q <= '0;
		end else if (cmd.load && (fill_q < FILL_W'(LIST_SIZE))) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// stored list, replaced all at once at the end of an update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LIST_SIZE; k++) begin
				act_q[k] <= EMPTY_PID;
			end
		end else if (cmd.copy) begin
			for (int k = 0; k < LIST_SIZE; k++) begin
				act_q[k] <= (FILL_W'(k) < fill_q) ? inc_q[k] : EMPTY_PID;
			end
		end
	end

	// pending result: held back until the next one shows whether it is final
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.take_hit) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.push) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_hit) begin
			pend_cmd_q <= sel_new_s1;
			pend_pid_q <= cand_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_cmd_q   <= pend_cmd_q;
			out_pid_q   <= pend_pid_q;
			out_final_q <= cmd.push_final;
		end
	end

	assign res_valid = out_valid_q;
	assign command   = out_cmd_q;
	assign pid_res   = out_pid_q;
	assign final_res = out_final_q;

endmodule

// ===== hw/rtl/pfsd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfsd_checker
// port-level checks of the pid filter list update block, bound to the core
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfsd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic                       last,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [pfsd_pkg::PID_W-1:0] pid_res
);
	import pfsd_pkg::*;

	// a stalled result stays offered
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	// the empty marker is never reported as a pid
	`ASSERT_IMPLIES(a_no_empty_pid, clk, arst_n, res_valid, pid_res != EMPTY_PID)

	// the closing entry of a list starts the compare and blocks input
	`ASSERT_NEXT(a_busy_after_last, clk, arst_n, item_valid && item_ready && last, !item_ready)

	// loading continues back to back until the closing entry
	`ASSERT_NEXT(a_load_streams, clk, arst_n, item_valid && item_ready && !last, item_ready)

endmodule

bind pid_filter_set_diff_core pfsd_checker u_pfsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.last      (last),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.pid_res   (pid_res)
);
